>>> rtl/shpc_pkg.sv
// Shared types, constants and the half-step table for the stepper position controller.
package shpc_pkg;

  localparam int MOTOR_COUNT = 3;
  localparam int SLOT_COUNT  = 3;
  localparam int PHASE_COUNT = 8;

  localparam int FUNC_W    = 2;
  localparam int MOTOR_W   = 2;
  localparam int TARGET_W  = 8;
  localparam int SPU_W     = 12;
  localparam int POS_W     = 5;
  localparam int IVL_W     = 8;
  localparam int STEPS_W   = 17;
  localparam int PHASE_W   = 3;
  localparam int COIL_W    = 4;
  localparam int REG_W     = 12;
  localparam int REG_IDX_W = 2;

  localparam logic [MOTOR_W-1:0] NO_MOTOR = 2'd3;

  localparam logic [SPU_W-1:0] SPU_RESET = 12'd2048;
  localparam logic [POS_W-1:0] MAX_POS_RESET = 5'd31;
  localparam logic [IVL_W-1:0] IVL_RESET = 8'd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_MOVE     = 2'd1,
    FUNC_MOVE_ALL = 2'd2,
    FUNC_MARK     = 2'd3
  } func_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STEPS_PER_UNIT = 2'd0,
    REG_MAX_POSITION   = 2'd1,
    REG_STEP_INTERVAL  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SPU_W-1:0] steps_per_unit;
    logic [POS_W-1:0] max_position;
    logic [IVL_W-1:0] step_interval;
  } cfg_t;

  typedef struct packed {
    logic [COIL_W-1:0]  coils_first;
    logic [COIL_W-1:0]  coils_second;
    logic [COIL_W-1:0]  coils_third;
    logic               relay_on;
    logic               busy_res;
    logic [MOTOR_W-1:0] active_motor;
    logic               rejected;
  } res_t;

  // Bit 3 drives the first coil.
  function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] idx);
    logic [COIL_W-1:0] c;
    case (idx)
      3'd0:    c = 4'b0001;
      3'd1:    c = 4'b0011;
      3'd2:    c = 4'b0010;
      3'd3:    c = 4'b0110;
      3'd4:    c = 4'b0100;
      3'd5:    c = 4'b1100;
      3'd6:    c = 4'b1000;
      default: c = 4'b1001;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/shpc_cmd_if.sv
// Command channel: tick, move, move-all and mark words.
interface shpc_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [shpc_pkg::FUNC_W-1:0]    func;
  logic [shpc_pkg::MOTOR_W-1:0]   motor;
  logic [shpc_pkg::TARGET_W-1:0]  target;

  modport source(output valid, func, motor, target, input ready);
  modport sink(input valid, func, motor, target, output ready);
endinterface

>>> rtl/shpc_res_if.sv
// Result channel: coil patterns and status for each command word.
interface shpc_res_if;
  logic                          valid;
  logic                          ready;
  logic [shpc_pkg::COIL_W-1:0]   coils_first;
  logic [shpc_pkg::COIL_W-1:0]   coils_second;
  logic [shpc_pkg::COIL_W-1:0]   coils_third;
  logic                          relay_on;
  logic                          busy_res;
  logic [shpc_pkg::MOTOR_W-1:0]  active_motor;
  logic                          rejected;

  modport source(output valid, coils_first, coils_second, coils_third, relay_on, busy_res,
                 active_motor, rejected, input ready);
  modport sink(input valid, coils_first, coils_second, coils_third, relay_on, busy_res,
               active_motor, rejected, output ready);
endinterface

>>> rtl/shpc_cfg_regs.sv
// Configuration registers: steps per unit, maximum position, step interval.
module shpc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [shpc_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [shpc_pkg::REG_W-1:0]     wr_data,
  output shpc_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steps_per_unit <= shpc_pkg::SPU_RESET;
      cfg.max_position   <= shpc_pkg::MAX_POS_RESET;
      cfg.step_interval  <= shpc_pkg::IVL_RESET;
    end else if (wr_en) begin
      unique case (shpc_pkg::reg_idx_t'(wr_index))
        shpc_pkg::REG_STEPS_PER_UNIT: cfg.steps_per_unit <= wr_data[shpc_pkg::SPU_W-1:0];
        shpc_pkg::REG_MAX_POSITION:   cfg.max_position   <= wr_data[shpc_pkg::POS_W-1:0];
        shpc_pkg::REG_STEP_INTERVAL:  cfg.step_interval  <= wr_data[shpc_pkg::IVL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/shpc_core.sv
// Motion state and the single-pass next-state logic for one command word.
module shpc_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [shpc_pkg::FUNC_W-1:0]   func,
  input  logic [shpc_pkg::MOTOR_W-1:0]  motor,
  input  logic [shpc_pkg::TARGET_W-1:0] target,
  input  shpc_pkg::cfg_t                cfg,
  output shpc_pkg::res_t                result
);

  localparam int SC = shpc_pkg::SLOT_COUNT;
  localparam int PW = shpc_pkg::POS_W;

  typedef struct packed {
    logic                          found;
    logic [shpc_pkg::MOTOR_W-1:0]  motor;
    logic [SC-1:0]                 pend;
    logic                          down;
    logic [shpc_pkg::STEPS_W-1:0]  steps;
  } start_t;

  logic [SC-1:0][PW-1:0]                  positions, positions_next;
  logic [SC-1:0][shpc_pkg::COIL_W-1:0]    coil_regs, coil_regs_next;
  logic [shpc_pkg::PHASE_W-1:0]           phase_index, phase_index_next;
  logic [shpc_pkg::STEPS_W-1:0]           steps_left, steps_left_next;
  logic                                   moving_down, moving_down_next;
  logic [shpc_pkg::MOTOR_W-1:0]           current_motor, current_motor_next;
  logic [SC-1:0]                          pending_motors, pending_motors_next;
  logic [PW-1:0]                          latched_target, latched_target_next;
  logic [shpc_pkg::IVL_W-1:0]             interval_count, interval_count_next;

  // Pick the first pending motor that actually has to move; clear the
  // pending bits up to and including it.
  function automatic start_t start_next(input logic [SC-1:0] pend,
                                        input logic [SC-1:0][PW-1:0] pos,
                                        input logic [PW-1:0] tgt,
                                        input shpc_pkg::cfg_t c);
    start_t s;
    logic [PW-1:0] sel_pos;
    logic [PW-1:0] delta;
    s.found = 1'b0;
    s.motor = shpc_pkg::NO_MOTOR;
    s.pend  = pend;
    s.down  = 1'b0;
    s.steps = '0;
    sel_pos = '0;
    for (int m = 0; m < SC; m++) begin
      if (!s.found && s.pend[m]) begin
        s.pend[m] = 1'b0;
        if (m < shpc_pkg::MOTOR_COUNT && pos[m] <= c.max_position && pos[m] != tgt) begin
          s.found = 1'b1;
          s.motor = shpc_pkg::MOTOR_W'(m);
          sel_pos = pos[m];
        end
      end
    end
    s.down  = tgt > sel_pos;
    delta   = s.down ? tgt - sel_pos : sel_pos - tgt;
    s.steps = shpc_pkg::STEPS_W'(c.steps_per_unit) * shpc_pkg::STEPS_W'(delta);
    if (!s.found) begin
      s.pend = '0;
    end
    return s;
  endfunction

  always_comb begin
    shpc_pkg::func_t                f;
    logic                           busy;
    logic                           rej;
    logic                           st_req;
    logic [SC-1:0]                  st_pend;
    logic [PW-1:0]                  st_tgt;
    logic [shpc_pkg::IVL_W-1:0]     ivl;
    logic [shpc_pkg::PHASE_W-1:0]   ph;
    start_t                         s;

    f       = shpc_pkg::func_t'(func);
    busy    = current_motor != shpc_pkg::NO_MOTOR;
    rej     = 1'b0;
    st_req  = 1'b0;
    st_pend = '0;
    st_tgt  = latched_target;
    ivl     = (cfg.step_interval == '0) ? shpc_pkg::IVL_W'(1) : cfg.step_interval;
    ph      = '0;

    positions_next      = positions;
    coil_regs_next      = coil_regs;
    phase_index_next    = phase_index;
    steps_left_next     = steps_left;
    moving_down_next    = moving_down;
    current_motor_next  = current_motor;
    pending_motors_next = pending_motors;
    latched_target_next = latched_target;
    interval_count_next = interval_count;

    if (take) begin
      unique case (f)
        shpc_pkg::FUNC_TICK: begin
          if (busy) begin
            if ({1'b0, interval_count} + 9'd1 < {1'b0, ivl}) begin
              interval_count_next = interval_count + 8'd1;
            end else begin
              interval_count_next = '0;
              if (steps_left != '0) begin
                ph = moving_down ? phase_index + 3'd1 : phase_index - 3'd1;
                phase_index_next = ph;
                coil_regs_next[current_motor] = shpc_pkg::half_step(ph);
                steps_left_next = steps_left - 17'd1;
              end else begin
                // Move done: release coils, store position, go to the next motor.
                coil_regs_next[current_motor] = '0;
                positions_next[current_motor] = latched_target;
                st_req  = 1'b1;
                st_pend = pending_motors;
              end
            end
          end
        end
        shpc_pkg::FUNC_MARK: begin
          if (busy) begin
            rej = 1'b1;
          end else begin
            for (int i = 0; i < SC; i++) begin
              positions_next[i] = cfg.max_position;
            end
          end
        end
        default: begin
          if (busy || target > shpc_pkg::TARGET_W'(cfg.max_position)) begin
            rej = 1'b1;
          end else if (f == shpc_pkg::FUNC_MOVE) begin
            if (int'(motor) >= shpc_pkg::MOTOR_COUNT) begin
              rej = 1'b1;
            end else begin
              st_req  = 1'b1;
              st_pend = SC'(1) << motor;
              st_tgt  = target[PW-1:0];
              latched_target_next = target[PW-1:0];
            end
          end else begin
            st_req  = 1'b1;
            for (int i = 0; i < SC; i++) begin
              st_pend[i] = (i < shpc_pkg::MOTOR_COUNT);
            end
            st_tgt  = target[PW-1:0];
            latched_target_next = target[PW-1:0];
          end
        end
      endcase
    end

    s = start_next(st_pend, positions_next, st_tgt, cfg);
    if (st_req) begin
      pending_motors_next = s.pend;
      if (s.found) begin
        current_motor_next  = s.motor;
        moving_down_next    = s.down;
        steps_left_next     = s.steps;
        interval_count_next = '0;
      end else begin
        current_motor_next  = shpc_pkg::NO_MOTOR;
      end
    end

    result.coils_first  = (0 < shpc_pkg::MOTOR_COUNT) ? coil_regs_next[0] : '0;
    result.coils_second = (1 < shpc_pkg::MOTOR_COUNT) ? coil_regs_next[1] : '0;
    result.coils_third  = (2 < shpc_pkg::MOTOR_COUNT) ? coil_regs_next[2] : '0;
    result.relay_on     = current_motor_next != shpc_pkg::NO_MOTOR;
    result.busy_res     = current_motor_next != shpc_pkg::NO_MOTOR;
    result.active_motor = current_motor_next;
    result.rejected     = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      positions      <= '0;
      coil_regs      <= '0;
      phase_index    <= '0;
      steps_left     <= '0;
      moving_down    <= 1'b0;
      current_motor  <= shpc_pkg::NO_MOTOR;
      pending_motors <= '0;
      latched_target <= '0;
      interval_count <= '0;
    end else begin
      positions      <= positions_next;
      coil_regs      <= coil_regs_next;
      phase_index    <= phase_index_next;
      steps_left     <= steps_left_next;
      moving_down    <= moving_down_next;
      current_motor  <= current_motor_next;
      pending_motors <= pending_motors_next;
      latched_target <= latched_target_next;
      interval_count <= interval_count_next;
    end
  end

endmodule

>>> rtl/shpc_out_reg.sv
// Result register: holds one result word and drives the result channel.
module shpc_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  shpc_pkg::res_t       d,
  output logic                 ready,
  shpc_res_if.source           res
);

  logic           valid;
  shpc_pkg::res_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data <= d;
    end
  end

  // Take a new word when the register is empty or the held one leaves in the same cycle.
  assign ready            = !valid || res.ready;
  assign res.valid        = valid;
  assign res.coils_first  = data.coils_first;
  assign res.coils_second = data.coils_second;
  assign res.coils_third  = data.coils_third;
  assign res.relay_on     = data.relay_on;
  assign res.busy_res     = data.busy_res;
  assign res.active_motor = data.active_motor;
  assign res.rejected     = data.rejected;

endmodule

>>> rtl/stepper_half_step_position_controller_unit.sv
// Top level of the half-step position controller for three unipolar steppers.
//
// Each command word (tick, move one motor, move all motors, mark all at maximum)
// is taken on a valid and ready handshake; its result word appears in the result
// register on the next cycle; a new word can be taken every cycle, and ready drops
// only while a result is held and the result side does not take it. The rate is
// set by the single registered pass from the command to the result register.
// Motion advances only on tick words: one half-step every step_interval ticks,
// steps_per_unit half-steps per unit of distance, then one more interval to
// release the coils and store the new position. Commands other than ticks
// that arrive while a move is running come back with rejected set. Configuration
// writes take effect on the next cycle and should be made while the block is idle.
module stepper_half_step_position_controller_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [shpc_pkg::REG_IDX_W-1:0] cfg_wr_index,
  input  logic [shpc_pkg::REG_W-1:0]     cfg_wr_data,
  shpc_cmd_if.sink                       cmd,
  shpc_res_if.source                     res
);

  shpc_pkg::cfg_t cfg;
  shpc_pkg::res_t result;
  logic           ready;
  logic           take;

  assign cmd.ready = ready;
  assign take      = cmd.valid && ready;

  shpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_wr_index),
    .wr_data  (cfg_wr_data),
    .cfg      (cfg)
  );

  shpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .func   (cmd.func),
    .motor  (cmd.motor),
    .target (cmd.target),
    .cfg    (cfg),
    .result (result)
  );

  shpc_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .d     (result),
    .ready (ready),
    .res   (res)
  );

endmodule

>>> rtl/shpc_checker.sv
// Port-level checks for the position controller, bound to the top level.
module shpc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic [shpc_pkg::FUNC_W-1:0]   cmd_func,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [shpc_pkg::COIL_W-1:0]   coils_first,
  input logic [shpc_pkg::COIL_W-1:0]   coils_second,
  input logic [shpc_pkg::COIL_W-1:0]   coils_third,
  input logic                          relay_on,
  input logic                          busy_res,
  input logic [shpc_pkg::MOTOR_W-1:0]  active_motor,
  input logic                          rejected
);

  // A stalled result word holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(coils_first) && $stable(coils_second)
      && $stable(coils_third) && $stable(active_motor) && $stable(rejected))
    else $error("result word changed while stalled");

  a_busy_motor: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (busy_res == relay_on) && (busy_res == (active_motor != shpc_pkg::NO_MOTOR)))
    else $error("busy, relay and active motor disagree");

  // Only the moving motor may have its coils energized.
  a_idle_coils: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (active_motor == 2'd0 || coils_first == '0)
      && (active_motor == 2'd1 || coils_second == '0)
      && (active_motor == 2'd2 || coils_third == '0))
    else $error("coils energized on a motor that is not moving");

  a_tick_not_rejected: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_func == shpc_pkg::FUNC_TICK |=> res_valid && !rejected)
    else $error("tick word missing or rejected");

endmodule

bind stepper_half_step_position_controller_unit shpc_checker u_shpc_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .cmd_func     (cmd.func),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .coils_first  (res.coils_first),
  .coils_second (res.coils_second),
  .coils_third  (res.coils_third),
  .relay_on     (res.relay_on),
  .busy_res     (res.busy_res),
  .active_motor (res.active_motor),
  .rejected     (res.rejected)
);

>>> verif/tb.sv
// Testbench for the stepper half-step position controller: directed table, then random words.
module tb;
  import shpc_pkg::*;

  localparam int HOLD_CYCLES  = 60;
  localparam int STALL_LIMIT  = 1000;
  localparam int WORD_BUDGET  = 950;
  localparam int PHASE_WORDS  = 120;
  localparam int SHOW_LIMIT   = 40;

  // Half-step coil patterns, entry n at bits 4n+3..4n.
  localparam logic [PHASE_COUNT*COIL_W-1:0] COIL_SEQ = 32'h98C46231;

  typedef enum {ROW_WORD, ROW_SETTINGS, ROW_SETTLE} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    func_t               fn;
    logic [MOTOR_W-1:0]  mot;
    logic [TARGET_W-1:0] tgt;
    bit                  typed;
    res_t                want;
    cfg_t                settings;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en;
  logic [REG_IDX_W-1:0] cfg_wr_index;
  logic [REG_W-1:0]     cfg_wr_data;

  shpc_cmd_if cmd_ch ();
  shpc_res_if res_ch ();

  stepper_half_step_position_controller_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd_ch),
    .res          (res_ch)
  );

  always #6 clk = ~clk;

  // Controller state as the checker sees it.
  cfg_t                  cfg;
  logic [POS_W-1:0]      stored_pos [SLOT_COUNT];
  logic [PHASE_W-1:0]    phase;
  logic [STEPS_W-1:0]    steps_left;
  bit                    toward_down;
  logic [MOTOR_W-1:0]    moving;
  logic [SLOT_COUNT-1:0] queued;
  logic [POS_W-1:0]      goal;
  logic [IVL_W-1:0]      ivl_count;
  logic [COIL_W-1:0]     coil [SLOT_COUNT];

  res_t      status_due [$];
  plan_row_t plan [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        words_sent = 0;
  int        idle_cycles = 0;
  int        hold_len = 0;
  bit        no_gaps = 1'b0;

  function automatic void clear_controller();
    cfg = '{SPU_RESET, MAX_POS_RESET, IVL_RESET};
    for (int m = 0; m < SLOT_COUNT; m++) begin
      stored_pos[m] = '0;
      coil[m] = '0;
    end
    phase = '0;
    steps_left = '0;
    toward_down = 1'b0;
    moving = NO_MOTOR;
    queued = '0;
    goal = '0;
    ivl_count = '0;
  endfunction

  // Pick the lowest queued motor that has somewhere to go.
  function automatic void launch_next();
    logic [POS_W-1:0] here;
    logic [POS_W-1:0] distance;
    for (int m = 0; m < SLOT_COUNT; m++) begin
      if (queued[m]) begin
        queued[m] = 1'b0;
        here = stored_pos[m];
        if (m < MOTOR_COUNT && here <= cfg.max_position && here != goal) begin
          toward_down = goal > here;
          distance = toward_down ? goal - here : here - goal;
          steps_left = STEPS_W'(cfg.steps_per_unit) * STEPS_W'(distance);
          ivl_count = '0;
          moving = MOTOR_W'(m);
          return;
        end
      end
    end
    queued = '0;
    moving = NO_MOTOR;
  endfunction

  function automatic void advance_tick();
    int span;
    span = (cfg.step_interval == 0) ? 1 : int'(cfg.step_interval);
    if (moving == NO_MOTOR) return;
    if (int'(ivl_count) + 1 < span) begin
      ivl_count = ivl_count + 1'b1;
      return;
    end
    ivl_count = '0;
    if (steps_left != 0) begin
      phase = toward_down ? phase + 1'b1 : phase - 1'b1;
      coil[moving] = COIL_SEQ[phase*COIL_W +: COIL_W];
      steps_left = steps_left - 1'b1;
    end else begin
      // Release the coils, store the position, hand over to the next motor.
      coil[moving] = '0;
      stored_pos[moving] = goal;
      launch_next();
    end
  endfunction

  function automatic res_t step_controller(input func_t fn, input logic [MOTOR_W-1:0] mot,
                                           input logic [TARGET_W-1:0] tgt);
    res_t r;
    bit   refused;
    refused = 1'b0;
    if (fn == FUNC_TICK) begin
      advance_tick();
    end else if (moving != NO_MOTOR) begin
      refused = 1'b1;
    end else if (fn == FUNC_MARK) begin
      for (int m = 0; m < SLOT_COUNT; m++) stored_pos[m] = cfg.max_position;
    end else if (tgt > TARGET_W'(cfg.max_position)) begin
      refused = 1'b1;
    end else if (fn == FUNC_MOVE) begin
      if (int'(mot) >= MOTOR_COUNT) begin
        refused = 1'b1;
      end else begin
        goal = tgt[POS_W-1:0];
        queued = '0;
        queued[mot] = 1'b1;
        launch_next();
      end
    end else begin
      goal = tgt[POS_W-1:0];
      queued = '0;
      for (int m = 0; m < MOTOR_COUNT; m++) queued[m] = 1'b1;
      launch_next();
    end
    r.coils_first  = coil[0];
    r.coils_second = coil[1];
    r.coils_third  = coil[2];
    r.relay_on     = moving != NO_MOTOR;
    r.busy_res     = moving != NO_MOTOR;
    r.active_motor = moving;
    r.rejected     = refused;
    return r;
  endfunction

  function automatic res_t shown(input logic [COIL_W-1:0] c0, input bit run,
                                 input logic [MOTOR_W-1:0] who, input bit refused);
    return '{c0, 4'h0, 4'h0, run, run, who, refused};
  endfunction

  function automatic void add_word(input func_t fn, input int mot, input int tgt);
    plan.push_back('{ROW_WORD, fn, MOTOR_W'(mot), TARGET_W'(tgt), 1'b0, '0, '0});
  endfunction

  function automatic void add_checked(input func_t fn, input int mot, input int tgt,
                                      input res_t want);
    plan.push_back('{ROW_WORD, fn, MOTOR_W'(mot), TARGET_W'(tgt), 1'b1, want, '0});
  endfunction

  function automatic void add_settings(input int spu, input int maxp, input int ivl);
    plan.push_back('{ROW_SETTINGS, FUNC_TICK, '0, '0, 1'b0, '0,
                     '{SPU_W'(spu), POS_W'(maxp), IVL_W'(ivl)}});
  endfunction

  function automatic void add_settle();
    plan.push_back('{ROW_SETTLE, FUNC_TICK, '0, '0, 1'b0, '0, '0});
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= SHOW_LIMIT)
      $display("mismatch on %s at result %0d: got %h, want %h", what, results_seen, got, want);
  endtask

  // Offer one command word and queue its status once the block takes it.
  task automatic offer_word(input func_t fn, input logic [MOTOR_W-1:0] mot,
                            input logic [TARGET_W-1:0] tgt, input bit typed, input res_t want);
    int   gap;
    res_t predicted;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid  <= 1'b1;
    cmd_ch.func   <= fn;
    cmd_ch.motor  <= mot;
    cmd_ch.target <= tgt;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    words_sent++;
    predicted = step_controller(fn, mot, tgt);
    status_due.push_back(typed ? want : predicted);
  endtask

  // Tick until the running move, or move-all sequence, has finished.
  task automatic run_out_motion();
    while (moving != NO_MOTOR)
      offer_word(FUNC_TICK, MOTOR_W'($urandom_range(0, 3)), TARGET_W'($urandom_range(0, 255)),
                 1'b0, '0);
  endtask

  // Write all three registers once every status word has come back.
  task automatic load_settings(input cfg_t s);
    cmd_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    cfg_wr_en    <= 1'b1;
    cfg_wr_index <= REG_STEPS_PER_UNIT;
    cfg_wr_data  <= s.steps_per_unit;
    @(posedge clk);
    cfg_wr_index <= REG_MAX_POSITION;
    cfg_wr_data  <= REG_W'(s.max_position);
    @(posedge clk);
    cfg_wr_index <= REG_STEP_INTERVAL;
    cfg_wr_data  <= REG_W'(s.step_interval);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg = s;
  endtask

  // Result side: random stalls, one long hold on request, field-by-field check.
  initial begin
    int   stall;
    res_t got;
    res_t want;
    res_ch.ready <= 1'b0;
    forever begin
      if (hold_len > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (rst || !res_ch.valid) @(posedge clk);
      got = {res_ch.coils_first, res_ch.coils_second, res_ch.coils_third, res_ch.relay_on,
             res_ch.busy_res, res_ch.active_motor, res_ch.rejected};
      results_seen++;
      if (status_due.size() == 0) begin
        report_mismatch("unexpected word", 8'(got), 8'h0);
      end else begin
        want = status_due.pop_front();
        if (got.coils_first !== want.coils_first)
          report_mismatch("coils_first", 8'(got.coils_first), 8'(want.coils_first));
        if (got.coils_second !== want.coils_second)
          report_mismatch("coils_second", 8'(got.coils_second), 8'(want.coils_second));
        if (got.coils_third !== want.coils_third)
          report_mismatch("coils_third", 8'(got.coils_third), 8'(want.coils_third));
        if (got.relay_on !== want.relay_on)
          report_mismatch("relay_on", 8'(got.relay_on), 8'(want.relay_on));
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        if (got.active_motor !== want.active_motor)
          report_mismatch("active_motor", 8'(got.active_motor), 8'(want.active_motor));
        if (got.rejected !== want.rejected)
          report_mismatch("rejected", 8'(got.rejected), 8'(want.rejected));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    res_t                idle_st;
    res_t                refused_st;
    func_t               fn;
    logic [MOTOR_W-1:0]  mot;
    logic [TARGET_W-1:0] tgt;
    cfg_t                s;
    int                  roll;
    int                  phase_words;
    int                  p;

    cmd_ch.valid  <= 1'b0;
    cmd_ch.func   <= FUNC_TICK;
    cmd_ch.motor  <= '0;
    cmd_ch.target <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_index  <= REG_STEPS_PER_UNIT;
    cfg_wr_data   <= '0;
    clear_controller();

    idle_st    = shown(4'h0, 1'b0, NO_MOTOR, 1'b0);
    refused_st = shown(4'h0, 1'b0, NO_MOTOR, 1'b1);

    // Reset settings: maximum position 31.
    add_checked(FUNC_TICK, 0, 0, idle_st);
    add_checked(FUNC_MOVE, 0, 0, idle_st);                   // already there
    add_checked(FUNC_MOVE, 3, 5, refused_st);                // no such motor
    add_checked(FUNC_MOVE_ALL, 0, 255, refused_st);          // target above maximum
    add_checked(FUNC_MOVE, 1, 32, refused_st);
    add_checked(FUNC_MARK, 0, 0, idle_st);
    add_checked(FUNC_MOVE, 2, 31, idle_st);
    // Two half-steps per unit keeps the move short.
    add_settings(2, 31, 1);
    add_checked(FUNC_MOVE, 0, 30, shown(4'h0, 1'b1, 2'd0, 1'b0));  // step backward
    add_checked(FUNC_TICK, 0, 0, shown(4'h9, 1'b1, 2'd0, 1'b0));
    add_checked(FUNC_TICK, 0, 0, shown(4'h8, 1'b1, 2'd0, 1'b0));
    add_checked(FUNC_MOVE, 1, 3, shown(4'h8, 1'b1, 2'd0, 1'b1));   // busy
    add_checked(FUNC_MARK, 0, 0, shown(4'h8, 1'b1, 2'd0, 1'b1));
    add_checked(FUNC_MOVE_ALL, 0, 0, shown(4'h8, 1'b1, 2'd0, 1'b1));
    add_word(FUNC_TICK, 3, 255);
    add_settle();
    // No half-steps and an interval of zero: each motor ends on the next tick.
    add_settings(0, 31, 0);
    add_checked(FUNC_MOVE, 0, 31, shown(4'h0, 1'b1, 2'd0, 1'b0));
    add_checked(FUNC_TICK, 0, 0, idle_st);
    add_word(FUNC_MOVE_ALL, 0, 29);
    add_word(FUNC_TICK, 0, 0);
    add_word(FUNC_TICK, 0, 0);
    add_word(FUNC_TICK, 0, 0);
    add_settle();
    // Stored positions now lie above the maximum: motors are skipped.
    add_settings(4095, 0, 1);
    add_checked(FUNC_MOVE_ALL, 0, 0, idle_st);
    add_checked(FUNC_MOVE, 1, 1, refused_st);
    add_checked(FUNC_MARK, 2, 7, idle_st);
    add_settings(3, 31, 1);
    add_word(FUNC_MOVE, 2, 1);
    add_settle();
    add_settings(0, 31, 255);
    add_word(FUNC_MOVE, 1, 3);
    add_settle();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_WORD:     offer_word(plan[i].fn, plan[i].mot, plan[i].tgt, plan[i].typed,
                                 plan[i].want);
        ROW_SETTINGS: load_settings(plan[i].settings);
        default:      run_out_motion();
      endcase
    end

    p = 0;
    while (words_sent < WORD_BUDGET) begin
      roll = $urandom_range(0, 9);
      s.steps_per_unit = roll < 8 ? SPU_W'($urandom_range(1, 3)) :
                         roll == 8 ? '0 : SPU_W'($urandom_range(4, 12));
      roll = $urandom_range(0, 9);
      s.step_interval  = roll < 8 ? IVL_W'($urandom_range(1, 3)) :
                         roll == 8 ? '0 : IVL_W'($urandom_range(4, 6));
      s.max_position   = POS_W'($urandom_range(0, 31));
      load_settings(s);
      no_gaps = (p % 3 == 2);
      if (p == 1) hold_len = HOLD_CYCLES;
      phase_words = 0;
      while (phase_words < PHASE_WORDS && words_sent < WORD_BUDGET) begin
        roll = $urandom_range(0, 99);
        mot = MOTOR_W'($urandom_range(0, 3));
        tgt = TARGET_W'($urandom_range(0, 255));
        if (moving != NO_MOTOR) begin
          // Mostly ticks while a move runs; the rest come back refused.
          fn = roll < 85 ? FUNC_TICK : func_t'(FUNC_W'($urandom_range(1, 3)));
        end else if (roll < 45) begin
          fn  = FUNC_MOVE;
          mot = MOTOR_W'($urandom_range(0, MOTOR_COUNT - 1));
          tgt = TARGET_W'($urandom_range(0, cfg.max_position));
        end else if (roll < 65) begin
          fn  = FUNC_MOVE_ALL;
          tgt = TARGET_W'($urandom_range(0, cfg.max_position));
        end else if (roll < 72) begin
          fn = FUNC_MARK;
        end else if (roll < 80) begin
          fn = FUNC_TICK;
        end else begin
          fn = func_t'(FUNC_W'($urandom_range(0, 3)));
        end
        phase_words++;
        offer_word(fn, mot, tgt, 1'b0, '0);
      end
      run_out_motion();
      p++;
    end

    cmd_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
